FILE: rtl/rwlc_pkg.sv
package rwlc_pkg;

  // sizing
  localparam int LAGS        = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 48;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int LAG_W       = $clog2(LAGS);
  localparam int FILL_W      = $clog2(LAGS + 1);

  // read select tree: groups of eight lags
  localparam int GRP_W  = 3;
  localparam int GRP    = 1 << GRP_W;
  localparam int NGRP   = LAGS / GRP;
  localparam int NGRP_W = LAG_W - GRP_W;

  // request function codes
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                    func;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic [5:0]                    lag_index;
  } in_req_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] acc_value;
    logic                       saturated;
  } out_rsp_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic shift;
    logic mul;
    logic add1;
    logic add2;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD1,
    ST_ADD2,
    ST_READ
  } state_e;

endpackage

FILE: rtl/ring_window_lag_correlator_core.sv
// Streaming lag correlator over a 64-pair window, built as a row of lag cells.
// Each cell keeps one window pair and one saturating 48-bit lag sum; cell 0
// holds the oldest pair, which is the time origin for the next push. While
// the window fills, a push only shifts the new pair in; once it is full, the
// products are registered in every cell as the window shifts, then the one
// or two saturating additions run in turn, only the first with symmetric_mode
// at 0. A read runs through a two-level registered lag select and lands in
// the output register. Requests are taken one at a time, and a new request
// is taken while a read result still waits at the output unless that
// request would need the output register.
// symmetric_mode is written through the cfg port while the block is idle.
module ring_window_lag_correlator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rwlc_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rwlc_pkg::out_rsp_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import rwlc_pkg::*;

  state_e                     state_q, state_d;
  cell_ctrl_t                 cell_ctrl;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic                       full;
  logic                       sym_q;
  logic                       in_acc;
  logic                       grp_ld, out_ld;
  logic                       out_valid_q, out_valid_d;
  out_rsp_t                   out_q;

  logic signed [SAMPLE_BITS-1:0] cell_a [LAGS];
  logic signed [SAMPLE_BITS-1:0] cell_b [LAGS];
  logic signed [ACC_BITS-1:0]    cell_sum [LAGS];
  logic                          cell_sat [LAGS];

  logic signed [ACC_BITS-1:0] grp_sum_q [NGRP];
  logic                       grp_sat_q [NGRP];
  logic [NGRP_W-1:0]          lag_hi_q;
  logic [GRP_W-1:0]           lag_lo;

  assign full   = (fill_q == FILL_W'(LAGS));
  assign in_acc = in_valid_i & ~in_stall_o;
  assign lag_lo = in_data_i.lag_index[GRP_W-1:0];

  // take a request only when idle; a read also needs the output to make room
  assign in_stall_o  = (state_q != ST_IDLE) |
                       (out_valid_q & out_stall_i & (in_data_i.func == FUNC_READ));
  assign cfg_ready_o = (state_q == ST_IDLE);

  // row of lag cells, the new pair enters at the far end
  for (genvar k = 0; k < LAGS; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] sh_a, sh_b;
    if (k == LAGS - 1) begin : g_last
      assign sh_a = in_data_i.sample_a;
      assign sh_b = in_data_i.sample_b;
    end else begin : g_mid
      assign sh_a = cell_a[k+1];
      assign sh_b = cell_b[k+1];
    end
    rwlc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .shift_a_i (sh_a),
      .shift_b_i (sh_b),
      .org_a_i   (cell_a[0]),
      .org_b_i   (cell_b[0]),
      .sym_i     (sym_q),
      .a_o       (cell_a[k]),
      .b_o       (cell_b[k]),
      .sum_o     (cell_sum[k]),
      .sat_o     (cell_sat[k])
    );
  end

  // sequencer: next state and cell commands
  always_comb begin
    state_d   = state_q;
    cell_ctrl = '0;
    fill_d    = fill_q;
    grp_ld    = 1'b0;
    out_ld    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.func)
            FUNC_PUSH: begin
              cell_ctrl.shift = 1'b1;
              if (full) begin
                cell_ctrl.mul = 1'b1;
                state_d       = ST_ADD1;
              end else begin
                fill_d = fill_q + 1'b1;
              end
            end
            FUNC_READ: begin
              grp_ld  = 1'b1;
              state_d = ST_READ;
            end
            FUNC_CLEAR: begin
              cell_ctrl.clear = 1'b1;
              fill_d          = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD1: begin
        cell_ctrl.add1 = 1'b1;
        state_d        = sym_q ? ST_ADD2 : ST_IDLE;
      end
      ST_ADD2: begin
        cell_ctrl.add2 = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_READ: begin
        out_ld  = 1'b1;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // symmetric_mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sym_q <= cfg_data_i;
    end
  end

  // first level of the lag select: one entry out of each group
  always_ff @(posedge clk_i) begin
    if (grp_ld) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_sum_q[g] <= cell_sum[g*GRP + int'(lag_lo)];
        grp_sat_q[g] <= cell_sat[g*GRP + int'(lag_lo)];
      end
      lag_hi_q <= in_data_i.lag_index[LAG_W-1:GRP_W];
    end
  end

  // output register
  assign out_valid_d = out_ld | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q.acc_value <= grp_sum_q[lag_hi_q];
      out_q.saturated <= grp_sat_q[lag_hi_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a result appears only out of the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ))
    else $error("result raised without a read");

  // a push into a full window starts the accumulate sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.func == FUNC_PUSH && full) |=> (state_q == ST_ADD1))
    else $error("full push did not start accumulation");

  // fill count never runs past the window depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(LAGS))
    else $error("fill count beyond window depth");
`endif

endmodule

FILE: rtl/rwlc_cell.sv
module rwlc_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rwlc_pkg::cell_ctrl_t                    ctrl_i,
  input  logic signed [rwlc_pkg::SAMPLE_BITS-1:0] shift_a_i,
  input  logic signed [rwlc_pkg::SAMPLE_BITS-1:0] shift_b_i,
  input  logic signed [rwlc_pkg::SAMPLE_BITS-1:0] org_a_i,
  input  logic signed [rwlc_pkg::SAMPLE_BITS-1:0] org_b_i,
  input  logic                                    sym_i,
  output logic signed [rwlc_pkg::SAMPLE_BITS-1:0] a_o,
  output logic signed [rwlc_pkg::SAMPLE_BITS-1:0] b_o,
  output logic signed [rwlc_pkg::ACC_BITS-1:0]    sum_o,
  output logic                                    sat_o
);
  import rwlc_pkg::*;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] a_q, b_q;
  logic signed [PROD_BITS-1:0]   p1_q, p2_q, p1_d, p2_d;
  logic signed [PROD_BITS-1:0]   addend;
  logic signed [ACC_BITS:0]      tot;
  logic signed [ACC_BITS-1:0]    sum_q, sum_d;
  logic                          sat_q, sat_d;
  logic                          do_add;

  // window pair, shifted towards the origin on every push
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      a_q <= shift_a_i;
      b_q <= shift_b_i;
    end
  end

  // cross products against the origin pair, taken before the shift
  assign p1_d = org_a_i * b_q;
  assign p2_d = a_q * org_b_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // saturating accumulate, one product per cycle
  assign do_add = ctrl_i.add1 | (ctrl_i.add2 & sym_i);
  assign addend = ctrl_i.add1 ? p1_q : p2_q;
  assign tot    = {sum_q[ACC_BITS-1], sum_q}
                + {{(ACC_BITS+1-PROD_BITS){addend[PROD_BITS-1]}}, addend};

  always_comb begin
    sum_d = sum_q;
    sat_d = sat_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      sat_d = 1'b0;
    end else if (do_add) begin
      if (tot[ACC_BITS] != tot[ACC_BITS-1]) begin
        sum_d = tot[ACC_BITS] ? ACC_MIN : ACC_MAX;
        sat_d = 1'b1;
      end else begin
        sum_d = tot[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      sat_q <= sat_d;
    end
  end

  assign a_o   = a_q;
  assign b_o   = b_q;
  assign sum_o = sum_q;
  assign sat_o = sat_q;

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwlc_pkg::*;

  // func 3 has no meaning in the block and must be ignored
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int RAND_PER_PHASE = 290;
  localparam int HOLD_OFF       = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [ACC_BITS-1:0] ACC_TWO31 = 48'sh0000_8000_0000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic     cfg_data_i  = 1'b0;

  ring_window_lag_correlator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  // directed stimulus table
  typedef struct {
    logic [1:0]                    func;
    logic signed [SAMPLE_BITS-1:0] a;
    logic signed [SAMPLE_BITS-1:0] b;
    logic [5:0]                    lag;
    int                            reps;
    bit                            pinned;
    logic signed [ACC_BITS-1:0]    acc;
    bit                            sat;
  } dir_row_t;

  localparam int DIR_ROWS = 17;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // reads straight after reset
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd0,  1, 1'b1, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd63, 1, 1'b1, 48'sd0, 1'b0},
    // partial fill, read before full, ignored func
    '{FUNC_PUSH,   16'sh7fff, 16'sh8000, 6'd0,  10, 1'b0, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd5,  1, 1'b1, 48'sd0, 1'b0},
    '{FUNC_UNUSED, 16'sh7fff, 16'sh8000, 6'd63, 2, 1'b0, 48'sd0, 1'b0},
    '{FUNC_CLEAR,  16'sh0000, 16'sh0000, 6'd0,  1, 1'b0, 48'sd0, 1'b0},
    // window full of the most negative sample, then one correlating push
    '{FUNC_PUSH,   16'sh8000, 16'sh8000, 6'd0,  LAGS, 1'b0, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd0,  1, 1'b1, 48'sd0, 1'b0},
    '{FUNC_PUSH,   16'sh8000, 16'sh8000, 6'd0,  1, 1'b0, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd0,  1, 1'b1, ACC_TWO31, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd63, 1, 1'b1, ACC_TWO31, 1'b0},
    '{FUNC_PUSH,   16'sh7fff, 16'sh8000, 6'd0,  3, 1'b0, 48'sd0, 1'b0},
    '{FUNC_PUSH,   16'sh0000, 16'shffff, 6'd0,  2, 1'b0, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd1,  1, 1'b0, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd62, 1, 1'b0, 48'sd0, 1'b0},
    '{FUNC_CLEAR,  16'sh0000, 16'sh0000, 6'd0,  1, 1'b0, 48'sd0, 1'b0},
    '{FUNC_READ,   16'sh0000, 16'sh0000, 6'd0,  1, 1'b1, 48'sd0, 1'b0}
  };

  // correlator state mirrored by the testbench
  logic signed [SAMPLE_BITS-1:0] win_a [LAGS];
  logic signed [SAMPLE_BITS-1:0] win_b [LAGS];
  longint                        lag_sum [LAGS];
  bit                            lag_sat [LAGS];
  int unsigned                   origin;
  int unsigned                   filled;
  bit                            sym_mode = 1'b1;

  // expected lag reads, with an optional hand-typed value per read request
  typedef struct {
    bit       pinned;
    out_rsp_t value;
  } read_pin_t;

  out_rsp_t  pending_reads [$];
  read_pin_t read_pins [$];

  int unsigned tx_max_gap = 0;
  int unsigned rx_max_gap = 0;
  bit          hold_off_req = 1'b0;
  int unsigned req_count = 0;
  int unsigned reads_checked = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;

  function void clear_correlator();
    for (int i = 0; i < LAGS; i++) begin
      win_a[i]   = '0;
      win_b[i]   = '0;
      lag_sum[i] = 0;
      lag_sat[i] = 1'b0;
    end
    origin = 0;
    filled = 0;
  endfunction

  // saturating add into one lag sum, sticky flag on overflow
  function void add_to_lag(int unsigned k, longint p);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    lo = -hi - 1;
    if (p > 0 && lag_sum[k] > hi - p) begin
      lag_sum[k] = hi;
      lag_sat[k] = 1'b1;
    end else if (p < 0 && lag_sum[k] < lo - p) begin
      lag_sum[k] = lo;
      lag_sat[k] = 1'b1;
    end else begin
      lag_sum[k] = lag_sum[k] + p;
    end
  endfunction

  // apply one accepted request, queueing the read result it yields
  function void apply_lag_request(in_req_t r);
    longint      ao;
    longint      bo;
    int unsigned s;
    out_rsp_t    rsp;
    case (r.func)
      FUNC_PUSH: begin
        if (filled < LAGS) begin
          win_a[filled] = r.sample_a;
          win_b[filled] = r.sample_b;
          filled++;
        end else begin
          ao = win_a[origin];
          bo = win_b[origin];
          for (int unsigned k = 0; k < LAGS; k++) begin
            s = (origin + k) % LAGS;
            add_to_lag(k, ao * win_b[s]);
            if (sym_mode) begin
              add_to_lag(k, win_a[s] * bo);
            end
          end
          win_a[origin] = r.sample_a;
          win_b[origin] = r.sample_b;
          origin = (origin + 1) % LAGS;
        end
      end
      FUNC_READ: begin
        rsp.acc_value = lag_sum[r.lag_index][ACC_BITS-1:0];
        rsp.saturated = lag_sat[r.lag_index];
        pending_reads.push_back(rsp);
      end
      FUNC_CLEAR: begin
        clear_correlator();
      end
      default: begin
      end
    endcase
  endfunction

  // monitor: check results, track requests and register writes
  always @(posedge clk_i) begin
    out_rsp_t  want;
    read_pin_t pin;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_reads.size() == 0) begin
          $error("result with no read request outstanding: acc_value %0d saturated %0d",
                 out_data_o.acc_value, out_data_o.saturated);
          fault_count++;
        end else begin
          want = pending_reads.pop_front();
          if (read_pins.size() != 0) begin
            pin = read_pins.pop_front();
            if (pin.pinned) begin
              want = pin.value;
            end
          end
          if (out_data_o.acc_value !== want.acc_value) begin
            $error("acc_value mismatch: expected %0d, got %0d",
                   want.acc_value, out_data_o.acc_value);
            fault_count++;
          end
          if (out_data_o.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0d, got %0d",
                   want.saturated, out_data_o.saturated);
            fault_count++;
          end
          reads_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        apply_lag_request(in_data_i);
        req_count++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sym_mode = cfg_data_i;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, rx_max_gap);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // offer one request after a random gap and wait for it to be taken
  task automatic send_req(in_req_t r, bit pinned, out_rsp_t pin_val);
    int unsigned gap;
    read_pin_t   pin;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (r.func == FUNC_READ) begin
      pin.pinned = pinned;
      pin.value  = pin_val;
      read_pins.push_back(pin);
    end
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // let outstanding reads return and any push finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (read_pins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(bit m);
    wait_idle();
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly pushes and reads, rare clears, some unused func codes
  function automatic in_req_t rand_req();
    in_req_t     r;
    int unsigned pick;
    r.sample_a  = rand_sample();
    r.sample_b  = rand_sample();
    r.lag_index = 6'($urandom_range(0, LAGS - 1));
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      r.func = FUNC_CLEAR;
    end else if (pick < 40) begin
      r.func = FUNC_UNUSED;
    end else if (pick < 340) begin
      r.func = FUNC_READ;
    end else begin
      r.func = FUNC_PUSH;
    end
    return r;
  endfunction

  initial begin
    in_req_t  r;
    out_rsp_t pin_val;
    bit       phase_mode [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
    int       phase_gap [4]  = '{9, 9, 0, 9};

    clear_correlator();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; window fill rows run without gaps
    for (int i = 0; i < DIR_ROWS; i++) begin
      tx_max_gap = (dir_rows[i].reps >= LAGS) ? 0 : 9;
      rx_max_gap = tx_max_gap;
      r.func      = dir_rows[i].func;
      r.sample_a  = dir_rows[i].a;
      r.sample_b  = dir_rows[i].b;
      r.lag_index = dir_rows[i].lag;
      pin_val.acc_value = dir_rows[i].acc;
      pin_val.saturated = dir_rows[i].sat;
      for (int n = 0; n < dir_rows[i].reps; n++) begin
        send_req(r, dir_rows[i].pinned, pin_val);
      end
    end

    // random phases over both mode settings
    for (int p = 0; p < 4; p++) begin
      set_mode(phase_mode[p]);
      tx_max_gap = phase_gap[p];
      rx_max_gap = phase_gap[p];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (p == 1 && n == RAND_PER_PHASE / 2) begin
          hold_off_req = 1'b1;
        end
        send_req(rand_req(), 1'b0, '0);
      end
    end

    wait_idle();
    if (pending_reads.size() != 0) begin
      $error("%0d expected read results never arrived", pending_reads.size());
      fault_count++;
    end

    $display("run covered %0d requests and %0d checked lag reads in both symmetry modes,",
             req_count, reads_checked);
    $display("with fill, clear, ignored func, extreme samples and a long output hold-off");
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
